// File: rtl/core/dmc_pkg.sv
package dmc_pkg;

	localparam int ROW_W   = 7;
	localparam int COL_W   = 8;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 3;
	localparam int DEPTH_W = 14;
	localparam int OP_W    = 2;
	localparam int DIR_W   = 2;
	localparam int CROWS_W = 6;
	localparam int CCOLS_W = 7;
	localparam int CDATA_W = 7;

	localparam int MAX_CELL_ROWS_DEF = 32;
	localparam int MAX_CELL_COLS_DEF = 64;
	localparam int STACK_DEPTH_DEF   = 8192;

	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;
	localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

	localparam logic [STAT_W-1:0] ST_STARTED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_CARVED   = 3'd1;
	localparam logic [STAT_W-1:0] ST_BACKTRAK = 3'd2;
	localparam logic [STAT_W-1:0] ST_REJECTED = 3'd3;
	localparam logic [STAT_W-1:0] ST_FINISHED = 3'd4;
	localparam logic [STAT_W-1:0] ST_READ_ANS = 3'd5;

	localparam logic [KIND_W-1:0] KIND_WALL    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PASSAGE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MARK    = 2'd2;

	localparam logic CFG_CELL_ROWS = 1'b0;
	localparam logic CFG_CELL_COLS = 1'b1;

	// left, right, up, down
	localparam int STEP_DR [4] = '{0, 0, -1, 1};
	localparam int STEP_DC [4] = '{-1, 1, 0, 0};

	typedef struct packed {
		logic in_ready;
		logic start;
		logic fin_idle;
		logic clr;
		logic stk_rd;
		logic top_cap;
		logic row_rd;
		logic dec;
		logic mrd;
		logic mwr;
		logic rrd;
		logic rwt;
		logic resp_load;
	} cmd_t;

	typedef struct packed {
		logic            in_valid;
		logic [OP_W-1:0] in_op;
		logic            step_idle;
		logic            clr_last;
		logic            clr_start;
		logic            row_last;
		logic            dec_push;
		logic            out_free;
	} sts_t;

endpackage

// File: rtl/core/dmc_ifs.sv
interface dmc_item_if;
	logic                        valid;
	logic                        ready;
	logic [dmc_pkg::OP_W-1:0]    operation;
	logic [dmc_pkg::DIR_W-1:0]   random_dir;
	logic [dmc_pkg::ROW_W-1:0]   read_row;
	logic [dmc_pkg::COL_W-1:0]   read_col;
	modport source(output valid, operation, random_dir, read_row, read_col, input ready);
	modport sink(input valid, operation, random_dir, read_row, read_col, output ready);
endinterface

interface dmc_result_if;
	logic                        valid;
	logic                        ready;
	logic [dmc_pkg::STAT_W-1:0]  status;
	logic [dmc_pkg::ROW_W-1:0]   cell_row;
	logic [dmc_pkg::COL_W-1:0]   cell_col;
	logic [dmc_pkg::KIND_W-1:0]  cell_kind;
	logic [dmc_pkg::DEPTH_W-1:0] depth_now;
	modport source(output valid, status, cell_row, cell_col, cell_kind, depth_now, input ready);
	modport sink(input valid, status, cell_row, cell_col, cell_kind, depth_now, output ready);
endinterface

interface dmc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic                        index;
	logic [dmc_pkg::CDATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/core/dmc_ram.sv
module dmc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: rtl/core/dmc_ctrl.sv
module dmc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  dmc_pkg::sts_t sts,
	output dmc_pkg::cmd_t cmd
);
	typedef enum logic [12:0] {
		S_CLEAR = 13'h0001,
		S_IDLE  = 13'h0002,
		S_STK   = 13'h0004,
		S_TOP   = 13'h0008,
		S_ROW   = 13'h0010,
		S_CAP   = 13'h0020,
		S_DEC   = 13'h0040,
		S_MRD   = 13'h0080,
		S_MWR   = 13'h0100,
		S_RRD   = 13'h0200,
		S_RWT   = 13'h0400,
		S_RESP  = 13'h0800,
		S_SPARE = 13'h1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = sts.clr_start ? S_RESP : S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					case (sts.in_op)
						dmc_pkg::OP_START: begin
							cmd.start = 1'b1;
							state_d = S_CLEAR;
						end
						dmc_pkg::OP_STEP: begin
							if (sts.step_idle) begin
								cmd.fin_idle = 1'b1;
								state_d = S_RESP;
							end else begin
								state_d = S_STK;
							end
						end
						dmc_pkg::OP_READ: state_d = S_RRD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_STK: begin
				cmd.stk_rd = 1'b1;
				state_d = S_TOP;
			end
			S_TOP: begin
				cmd.top_cap = 1'b1;
				state_d = S_ROW;
			end
			S_ROW: begin
				cmd.row_rd = 1'b1;
				if (sts.row_last) begin
					state_d = S_CAP;
				end
			end
			S_CAP: state_d = S_DEC;
			S_DEC: begin
				cmd.dec = 1'b1;
				state_d = sts.dec_push ? S_MRD : S_RESP;
			end
			S_MRD: begin
				cmd.mrd = 1'b1;
				state_d = S_MWR;
			end
			S_MWR: begin
				cmd.mwr = 1'b1;
				state_d = S_RESP;
			end
			S_RRD: begin
				cmd.rrd = 1'b1;
				state_d = S_RWT;
			end
			S_RWT: begin
				cmd.rwt = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.resp_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// File: rtl/core/dmc_datapath.sv
module dmc_datapath #(
	parameter int MAX_CELL_ROWS = dmc_pkg::MAX_CELL_ROWS_DEF,
	parameter int MAX_CELL_COLS = dmc_pkg::MAX_CELL_COLS_DEF,
	parameter int STACK_DEPTH   = dmc_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dmc_cfg_if.sink       cfg,
	dmc_item_if.sink      item,
	dmc_result_if.source  result,
	input  dmc_pkg::cmd_t cmd,
	output dmc_pkg::sts_t sts
);
	localparam int ROW_W    = dmc_pkg::ROW_W;
	localparam int COL_W    = dmc_pkg::COL_W;
	localparam int SE_W     = ROW_W + COL_W;
	localparam int TOP_W    = $clog2(STACK_DEPTH + 1);
	localparam int STK_AW   = $clog2(STACK_DEPTH);
	localparam int MAP_ROWS = 2 * MAX_CELL_ROWS + 1;
	localparam int MAP_COLS = 2 * MAX_CELL_COLS + 1;
	localparam int MR_AW    = $clog2(MAP_ROWS);
	localparam int MC_IW    = $clog2(MAP_COLS);

	// config
	logic [dmc_pkg::CROWS_W-1:0] cell_rows_q;
	logic [dmc_pkg::CCOLS_W-1:0] cell_cols_q;
	logic [7:0] rows_n, cols_n, gr;
	logic [8:0] gc;

	// control state
	logic [TOP_W-1:0] top_q;
	logic             done_q, vis11_q, start_mode_q;
	logic [MR_AW-1:0] clr_cnt_q;
	logic [2:0]       row_cnt_q, row_idx_s1;
	logic             row_vld_s1, row_ok_s1, out_valid_q;

	// payload
	logic [dmc_pkg::DIR_W-1:0] dir_q;
	logic [ROW_W-1:0] rd_row_q, tr_q, nr_q;
	logic [COL_W-1:0] rd_col_q, tc_q, nc_q;
	logic [4:0][4:0]  win_q;
	logic [dmc_pkg::STAT_W-1:0]  res_status_q, out_status_q;
	logic [ROW_W-1:0]            res_row_q, out_row_q;
	logic [COL_W-1:0]            res_col_q, out_col_q;
	logic [dmc_pkg::KIND_W-1:0]  res_kind_q, out_kind_q;
	logic [dmc_pkg::DEPTH_W-1:0] res_depth_q, out_depth_q;

	// memories
	logic              stk_we;
	logic [STK_AW-1:0] stk_waddr;
	logic [SE_W-1:0]   stk_wdata, stk_rdata;
	logic              map_we, map_re;
	logic [MR_AW-1:0]  map_waddr, map_raddr;
	logic [MAP_COLS-1:0] map_wdata, map_rdata;

	logic accept, full, any_ok, push, rd_rowin, rd_colin, rd_vis, rd_ingrid, rd_mark, rd_start;
	logic [3:0] ok;
	logic [9:0] rr_a [4];
	logic [9:0] cc_a [4];
	logic [8:0] rowx;
	logic       row_ok;
	logic [4:0] win_row;
	logic [TOP_W-1:0] top_m1;
	logic [dmc_pkg::KIND_W-1:0] rd_kind;

	assign cfg.ready  = 1'b1;
	assign item.ready = cmd.in_ready;
	assign accept     = item.valid & cmd.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_rows_q <= dmc_pkg::CROWS_W'(2);
			cell_cols_q <= dmc_pkg::CCOLS_W'(2);
		end else if (cfg.valid) begin
			if (cfg.index == dmc_pkg::CFG_CELL_ROWS) begin
				cell_rows_q <= cfg.data[dmc_pkg::CROWS_W-1:0];
			end else begin
				cell_cols_q <= cfg.data[dmc_pkg::CCOLS_W-1:0];
			end
		end
	end

	always_comb begin
		if (cell_rows_q < dmc_pkg::CROWS_W'(2)) rows_n = 8'd2;
		else if (8'(cell_rows_q) > 8'(MAX_CELL_ROWS)) rows_n = 8'(MAX_CELL_ROWS);
		else rows_n = 8'(cell_rows_q);
		if (cell_cols_q < dmc_pkg::CCOLS_W'(2)) cols_n = 8'd2;
		else if (8'(cell_cols_q) > 8'(MAX_CELL_COLS)) cols_n = 8'(MAX_CELL_COLS);
		else cols_n = 8'(cell_cols_q);
		gr = {rows_n[6:0], 1'b0} - 8'd1;
		gc = {cols_n, 1'b0} - 9'd1;
	end

	// neighbour window, center at [2][2]
	always_comb begin
		int a, b;
		logic u, dn, l, r, self_v, in_rng;
		for (int d = 0; d < 4; d++) begin
			a = 2 + dmc_pkg::STEP_DR[d];
			b = 2 + dmc_pkg::STEP_DC[d];
			rr_a[d] = 10'(tr_q) + 10'(dmc_pkg::STEP_DR[d]);
			cc_a[d] = 10'(tc_q) + 10'(dmc_pkg::STEP_DC[d]);
			self_v = win_q[a][b];
			u  = win_q[a-1][b];
			dn = win_q[a+1][b];
			l  = win_q[a][b-1];
			r  = win_q[a][b+1];
			in_rng = (rr_a[d] != 10'd0) && (rr_a[d] <= 10'(gr))
			      && (cc_a[d] != 10'd0) && (cc_a[d] <= 10'(gc));
			ok[d] = in_rng && !self_v && ((!u && !dn && !(l && r)) || (!l && !r)) && !(u && dn);
		end
	end

	assign any_ok = |ok;
	assign full   = top_q >= TOP_W'(STACK_DEPTH);
	assign push   = ok[dir_q] && !full;
	assign top_m1 = top_q - TOP_W'(1);

	// row fetch: tr-2 .. tr+2
	assign rowx   = 9'(tr_q) + 9'(row_cnt_q);
	assign row_ok = (rowx >= 9'd2) && ((rowx - 9'd2) < 9'(MAP_ROWS));

	always_comb begin
		logic [9:0] colx;
		for (int j = 0; j < 5; j++) begin
			colx = 10'(tc_q) + 10'(j);
			win_row[j] = row_ok_s1 && (colx >= 10'd2) && ((colx - 10'd2) < 10'(MAP_COLS))
			          && map_rdata[MC_IW'(colx - 10'd2)];
		end
	end

	// read op
	assign rd_rowin  = 9'(rd_row_q) < 9'(MAP_ROWS);
	assign rd_colin  = 10'(rd_col_q) < 10'(MAP_COLS);
	assign rd_vis    = rd_rowin && rd_colin && map_rdata[MC_IW'(rd_col_q)];
	assign rd_ingrid = (9'(rd_row_q) <= 9'(gr) + 9'd1) && (10'(rd_col_q) <= 10'(gc) + 10'd1);
	assign rd_start  = (rd_row_q == ROW_W'(1)) && (rd_col_q == COL_W'(1));
	assign rd_mark   = done_q && vis11_q
	                && (rd_start || ((8'(rd_row_q) == gr) && (9'(rd_col_q) == gc)));
	always_comb begin
		if (!rd_ingrid) rd_kind = dmc_pkg::KIND_WALL;
		else if (rd_mark) rd_kind = dmc_pkg::KIND_MARK;
		else if (!rd_start && rd_vis) rd_kind = dmc_pkg::KIND_PASSAGE;
		else rd_kind = dmc_pkg::KIND_WALL;
	end

	// memory ports
	always_comb begin
		stk_we    = cmd.start | (cmd.dec & push);
		stk_waddr = cmd.start ? STK_AW'(0) : top_q[STK_AW-1:0];
		stk_wdata = cmd.start ? {ROW_W'(1), COL_W'(1)}
		                      : {ROW_W'(rr_a[dir_q]), COL_W'(cc_a[dir_q])};
		map_we    = cmd.clr | cmd.mwr;
		map_waddr = cmd.clr ? clr_cnt_q : MR_AW'(nr_q);
		if (cmd.clr) begin
			map_wdata = (start_mode_q && clr_cnt_q == MR_AW'(1)) ? MAP_COLS'(2) : '0;
		end else begin
			map_wdata = map_rdata | (MAP_COLS'(1) << nc_q);
		end
		map_re = cmd.row_rd | cmd.mrd | cmd.rrd;
		if (cmd.row_rd) map_raddr = MR_AW'(rowx - 9'd2);
		else if (cmd.mrd) map_raddr = MR_AW'(nr_q);
		else map_raddr = MR_AW'(rd_row_q);
	end

	dmc_ram #(.WIDTH(SE_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(cmd.stk_rd), .raddr(top_m1[STK_AW-1:0]), .rdata(stk_rdata)
	);

	dmc_ram #(.WIDTH(MAP_COLS), .DEPTH(MAP_ROWS)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.re(map_re), .raddr(map_raddr), .rdata(map_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q        <= '0;
			done_q       <= 1'b1;
			vis11_q      <= 1'b0;
			start_mode_q <= 1'b0;
			clr_cnt_q    <= '0;
			row_cnt_q    <= '0;
			row_vld_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			row_vld_s1 <= cmd.row_rd;
			if (cmd.start) begin
				top_q        <= TOP_W'(1);
				done_q       <= 1'b0;
				vis11_q      <= 1'b1;
				start_mode_q <= 1'b1;
				clr_cnt_q    <= '0;
			end
			if (cmd.clr) clr_cnt_q <= clr_cnt_q + MR_AW'(1);
			if (cmd.fin_idle) done_q <= 1'b1;
			if (cmd.top_cap) row_cnt_q <= '0;
			if (cmd.row_rd) row_cnt_q <= row_cnt_q + 3'd1;
			if (cmd.dec) begin
				if (!any_ok || (ok[dir_q] && full)) begin
					top_q <= top_m1;
					if (top_m1 == '0) done_q <= 1'b1;
				end else if (push) begin
					top_q <= top_q + TOP_W'(1);
				end
			end
			if (cmd.resp_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			dir_q    <= item.random_dir;
			rd_row_q <= item.read_row;
			rd_col_q <= item.read_col;
		end
		if (cmd.top_cap) {tr_q, tc_q} <= stk_rdata;
		row_idx_s1 <= row_cnt_q;
		row_ok_s1  <= row_ok;
		if (row_vld_s1) win_q[row_idx_s1] <= win_row;
		if (cmd.start) begin
			res_status_q <= dmc_pkg::ST_STARTED;
			res_row_q    <= ROW_W'(1);
			res_col_q    <= COL_W'(1);
			res_kind_q   <= dmc_pkg::KIND_WALL;
			res_depth_q  <= dmc_pkg::DEPTH_W'(1);
		end
		if (cmd.fin_idle) begin
			res_status_q <= dmc_pkg::ST_FINISHED;
			res_row_q    <= '0;
			res_col_q    <= '0;
			res_kind_q   <= dmc_pkg::KIND_WALL;
			res_depth_q  <= '0;
		end
		if (cmd.dec) begin
			res_kind_q <= dmc_pkg::KIND_WALL;
			nr_q       <= ROW_W'(rr_a[dir_q]);
			nc_q       <= COL_W'(cc_a[dir_q]);
			if (!any_ok || (ok[dir_q] && full)) begin
				res_status_q <= (top_m1 == '0) ? dmc_pkg::ST_FINISHED : dmc_pkg::ST_BACKTRAK;
				res_row_q    <= tr_q;
				res_col_q    <= tc_q;
				res_depth_q  <= dmc_pkg::DEPTH_W'(top_m1);
			end else if (push) begin
				res_status_q <= dmc_pkg::ST_CARVED;
				res_row_q    <= ROW_W'(rr_a[dir_q]);
				res_col_q    <= COL_W'(cc_a[dir_q]);
				res_depth_q  <= dmc_pkg::DEPTH_W'(top_q + TOP_W'(1));
			end else begin
				res_status_q <= dmc_pkg::ST_REJECTED;
				res_row_q    <= '0;
				res_col_q    <= '0;
				res_depth_q  <= dmc_pkg::DEPTH_W'(top_q);
			end
		end
		if (cmd.rwt) begin
			res_status_q <= dmc_pkg::ST_READ_ANS;
			res_row_q    <= rd_row_q;
			res_col_q    <= rd_col_q;
			res_kind_q   <= rd_kind;
			res_depth_q  <= dmc_pkg::DEPTH_W'(top_q);
		end
		if (cmd.resp_load) begin
			out_status_q <= res_status_q;
			out_row_q    <= res_row_q;
			out_col_q    <= res_col_q;
			out_kind_q   <= res_kind_q;
			out_depth_q  <= res_depth_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.status    = out_status_q;
	assign result.cell_row  = out_row_q;
	assign result.cell_col  = out_col_q;
	assign result.cell_kind = out_kind_q;
	assign result.depth_now = out_depth_q;

	always_comb begin
		sts.in_valid  = item.valid;
		sts.in_op     = item.operation;
		sts.step_idle = done_q || (top_q == '0);
		sts.clr_last  = clr_cnt_q == MR_AW'(MAP_ROWS - 1);
		sts.clr_start = start_mode_q;
		sts.row_last  = row_cnt_q == 3'd4;
		sts.dec_push  = push;
		sts.out_free  = !out_valid_q || result.ready;
	end
endmodule

// File: rtl/core/dfs_maze_carver_unit.sv
// Depth-first maze carver on a bordered grid of (2*rows-1) x (2*cols-1) cells.
// Channels: item (valid/ready) carries operation, random_dir, read_row,
// read_col; result (valid/ready) returns one transaction per start, step or
// read; cfg (valid/ready, always ready) writes cell_rows (index 0) and
// cell_cols (index 1); the user must write only while the block is idle.
// This is not enforced. Operation 3 is dropped and gives no result transaction.
// Steps from accept to result valid, when the result side is free:
//   start : a row-per-cycle clear of the visited map
//   step  : on pop or rejected draw, one stack read and five bitmap row reads
//           for the 5x5 neighbour window; on carve also a read-modify-write
//           of the carved row
//   step while finished : no memory access; read : one bitmap row read.
// One item is in work at a time; the next is taken once the previous result
// sits in the output register, so a stalled receiver holds at most one
// finished result plus one that waits in the controller.
// Reset: the visited map is cleared by a pass over all MAP_ROWS rows, during
// which item.ready is low; the stack top resets to 0 and the block is idle
// in the finished state. Config registers reset to 2.
module dfs_maze_carver_unit #(
	parameter int MAX_CELL_ROWS = dmc_pkg::MAX_CELL_ROWS_DEF,
	parameter int MAX_CELL_COLS = dmc_pkg::MAX_CELL_COLS_DEF,
	parameter int STACK_DEPTH   = dmc_pkg::STACK_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dmc_cfg_if.sink      cfg,
	dmc_item_if.sink     item,
	dmc_result_if.source result
);
	dmc_pkg::cmd_t cmd;
	dmc_pkg::sts_t sts;

	// sequencer: one-hot states, no payload
	dmc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd)
	);

	// bitmap, stack, window, pruning and result registers
	dmc_datapath #(
		.MAX_CELL_ROWS(MAX_CELL_ROWS),
		.MAX_CELL_COLS(MAX_CELL_COLS),
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .item(item), .result(result),
		.cmd(cmd), .sts(sts)
	);
endmodule
